/* rtl/sha_pkg.sv */
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } sha_state_t;

  // Datapath commands from the controller
  typedef struct packed {
    logic       take_byte;    // write the input byte at the fill position
    logic       pad_start;    // capture length, write 0x80 at the fill position
    logic       pad_zero;     // write zero at pad_idx
    logic       pad_len;      // pad_idx is a length byte position
    logic [5:0] pad_idx;
    logic       round_load;   // load working vars from hash, clear round count
    logic       round_step;   // advance one round
    logic       fold;         // add working vars into the hash
    logic       add_block;    // add 512 to the bit count
    logic       restart;      // back to initial hash values
    logic       emit_shift;   // rotate the hash words to bring the next one to the head
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
  } sha_sts_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha_dp.sv */
module sha_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [7:0]       in_byte,
  output sha_pkg::sha_sts_t sts,
  output logic [31:0]      head_word
);

  // block bytes held as sixteen big-endian schedule words; shifted down in place during rounds
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  round_r;
  logic [54:0] blocks_r;            // bit count in units of 512
  logic [63:0] total_r;

  logic [31:0] s0, s1, w_new, t1, t2;
  logic [5:0]  wr_idx;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [2:0]  len_sel;

  assign s0 = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + s0 + w_r[9] + s1;
  assign t1 = hh_r + (sha_pkg::rotr(e_r, 6) ^ sha_pkg::rotr(e_r, 11) ^ sha_pkg::rotr(e_r, 25))
            + ((e_r & f_r) ^ (~e_r & g_r)) + sha_pkg::RoundK[round_r] + w_r[0];
  assign t2 = (sha_pkg::rotr(a_r, 2) ^ sha_pkg::rotr(a_r, 13) ^ sha_pkg::rotr(a_r, 22))
            + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  assign len_sel = cmd.pad_idx[2:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cmd.pad_idx;
    wr_byte = 8'h00;
    if (cmd.take_byte) begin
      wr_en = 1'b1; wr_idx = fill_r; wr_byte = in_byte;
    end else if (cmd.pad_start) begin
      wr_en = 1'b1; wr_idx = fill_r; wr_byte = sha_pkg::PadByte;
    end else if (cmd.pad_zero) begin
      wr_en = 1'b1;
      wr_byte = cmd.pad_len ? total_r[8'(7 - len_sel) * 8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    w_nxt = w_r;
    if (wr_en) w_nxt[wr_idx[5:2]][8'(3 - wr_idx[1:0]) * 8 +: 8] = wr_byte;
    if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[15] = w_new;
    end
  end

  always_comb begin
    h_nxt = h_r;
    if (cmd.restart) h_nxt = sha_pkg::HashInit;
    else if (cmd.fold) begin
      h_nxt[0] = h_r[0] + a_r; h_nxt[1] = h_r[1] + b_r;
      h_nxt[2] = h_r[2] + c_r; h_nxt[3] = h_r[3] + d_r;
      h_nxt[4] = h_r[4] + e_r; h_nxt[5] = h_r[5] + f_r;
      h_nxt[6] = h_r[6] + g_r; h_nxt[7] = h_r[7] + hh_r;
    end else if (cmd.emit_shift) begin
      for (int i = 0; i < 7; i++) h_nxt[i] = h_r[i + 1];
      h_nxt[7] = h_r[0];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.restart) fill_nxt = '0;
    else if (cmd.take_byte) fill_nxt = fill_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (cmd.pad_start) total_r <= {blocks_r, fill_r, 3'b000};
    if (cmd.round_load) begin
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
      e_r <= h_r[4]; f_r <= h_r[5]; g_r <= h_r[6]; hh_r <= h_r[7];
    end else if (cmd.round_step) begin
      hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r      <= sha_pkg::HashInit;
      fill_r   <= '0;
      blocks_r <= '0;
      round_r  <= '0;
    end else begin
      h_r    <= h_nxt;
      fill_r <= fill_nxt;
      if (cmd.restart) blocks_r <= '0;
      else if (cmd.add_block) blocks_r <= blocks_r + 55'd1;
      if (cmd.round_load) round_r <= '0;
      else if (cmd.round_step) round_r <= round_r + 6'd1;
    end
  end

  assign sts.fill  = fill_r;
  assign sts.round = round_r;
  assign head_word = h_r[0];

endmodule

/* rtl/sha_ctrl.sv */
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              has_data,
  input  logic              end_of_message,
  input  logic              out_stall,
  input  sha_pkg::sha_sts_t sts,
  output logic              in_stall,
  output logic              out_valid,
  output logic [2:0]        word_index,
  output sha_pkg::sha_cmd_t cmd
);

  sha_pkg::sha_state_t state_r, state_nxt;
  logic       final_r, final_nxt;   // current block is the last of the message
  logic       fin_pend_r, fin_pend_nxt; // pad after this block compresses
  logic [5:0] pidx_r, pidx_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       acc;

  assign in_stall = (state_r != sha_pkg::ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_valid  = (state_r == sha_pkg::ST_EMIT);
  assign word_index = widx_r;

  always_comb begin
    state_nxt    = state_r;
    final_nxt    = final_r;
    fin_pend_nxt = fin_pend_r;
    pidx_nxt     = pidx_r;
    widx_nxt     = widx_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (acc) begin
          if (has_data && sts.fill == 6'd63) begin
            state_nxt = sha_pkg::ST_ROUND; final_nxt = 1'b0; fin_pend_nxt = end_of_message;
          end else if (end_of_message) begin
            state_nxt = sha_pkg::ST_MARK;
            final_nxt = (has_data ? sts.fill + 6'd1 : sts.fill) < 6'd56;
          end
        end
      end
      sha_pkg::ST_MARK: begin
        // 0x80 in the last byte leaves nothing to sweep in this block
        if (sts.fill == 6'd63) begin
          state_nxt = sha_pkg::ST_ROUND; pidx_nxt = 6'd63;
        end else begin
          state_nxt = sha_pkg::ST_PAD; pidx_nxt = sts.fill + 6'd1;
        end
      end
      sha_pkg::ST_PAD: begin
        if (pidx_r == 6'd63) begin
          state_nxt = sha_pkg::ST_ROUND;
        end else begin
          pidx_nxt = pidx_r + 6'd1;
        end
      end
      sha_pkg::ST_ROUND: if (sts.round == 6'd63) state_nxt = sha_pkg::ST_FOLD;
      sha_pkg::ST_FOLD: begin
        if (final_r) begin
          state_nxt = sha_pkg::ST_EMIT; widx_nxt = '0;
        end else if (fin_pend_r) begin
          // message ended on a block edge: pad a fresh block
          fin_pend_nxt = 1'b0; final_nxt = 1'b1;
          state_nxt = sha_pkg::ST_MARK;
        end else if (pidx_r != 6'd0) begin
          // second pad block of zeros and length
          final_nxt = 1'b1; state_nxt = sha_pkg::ST_PAD; pidx_nxt = 6'd0;
        end else begin
          state_nxt = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_EMIT: begin
        if (!out_stall) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            state_nxt = sha_pkg::ST_IDLE; final_nxt = 1'b0; pidx_nxt = '0;
          end
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.pad_idx = pidx_r;
    cmd.pad_len = pidx_r >= 6'd56 && final_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        cmd.take_byte = acc && has_data;
        cmd.round_load = 1'b1;
      end
      sha_pkg::ST_MARK: begin
        cmd.pad_start = 1'b1;
        cmd.round_load = 1'b1;
      end
      sha_pkg::ST_PAD: begin
        // zero the rest of the block, length bytes at the tail of the final one
        cmd.pad_zero = 1'b1;
        cmd.pad_idx  = pidx_r;
        cmd.round_load = 1'b1;
      end
      sha_pkg::ST_ROUND: cmd.round_step = 1'b1;
      sha_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        cmd.add_block = !final_r && pidx_r == 6'd0;
      end
      sha_pkg::ST_EMIT: begin
        cmd.emit_shift = !out_stall;
        cmd.restart = !out_stall && widx_r == 3'd7;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE; final_r <= 1'b0; fin_pend_r <= 1'b0;
      pidx_r <= '0; widx_r <= '0;
    end else begin
      state_r <= state_nxt; final_r <= final_nxt; fin_pend_r <= fin_pend_nxt;
      pidx_r <= pidx_nxt; widx_r <= widx_nxt;
    end
  end

endmodule

/* rtl/sha256_stream_hasher.sv */
// SHA-256 stream hasher.
// Input channel: in_valid/in_stall with in_data_byte, in_has_data and
// in_end_of_message. A word with has_data appends one message byte; a word
// with end_of_message (with or without a byte) closes the message.
// Output channel: out_valid/out_stall carrying eight digest words per
// message, out_word_index 0 (most significant) to 7, out_last_word on 7.
// A plain byte is taken at one per cycle while in_stall is low. The 64th
// byte of a block starts one compression: 64 rounds, one round per cycle in
// a single round unit, then a fold into the hash, with the input stalled
// meanwhile, so no new byte is taken until the compression is through.
// Closing a message adds a step to place the 0x80 marker, a sweep over the
// rest of the block and one or two compressions, then the eight digest
// words. While the receiver stalls, hold the current
// digest word and keep the input stalled. Reset (rst_n low, synchronous)
// restores the initial hash values, clears byte and bit counts and drops any
// pending output. After the last word the hash restarts for a new message.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_data,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::sha_sts_t sts;

  // sequence padding, rounds and word output
  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .has_data(in_has_data), .end_of_message(in_end_of_message),
    .out_stall, .sts, .in_stall, .out_valid, .word_index(out_word_index), .cmd
  );

  // block buffer, schedule, round unit and hash state
  sha_dp u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_data_byte), .sts, .head_word(out_digest_word)
  );

  assign out_last_word = (out_word_index == 3'd7);

`ifndef SYNTHESIS
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during output");
  a_idx_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_word_index != 3'd7 |=> out_valid)
    else $error("digest words broken");
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word_index) && $stable(out_digest_word))
    else $error("output moved under stall");
`endif

endmodule
